FILE: rtl/core/dtmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DTMF tone generator package
// Shared types, register indexes, reset values and key decoding for the
// dual-tone generator and its sub-blocks.
// ----------------------------------------------------------------------------
package dtmf_pkg;

    // Default build parameters.
    localparam int DEF_SAMPLE_RATE_HZ   = 8000;
    localparam int DEF_SINE_TABLE_DEPTH = 1024;

    // Input commands.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TONE_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_OFFSET = 2'd2;

    // Configuration reset values.
    localparam logic [15:0] VOLUME_RST     = 16'd13107;
    localparam logic [11:0] TONE_LEN_RST   = 12'd400;
    localparam logic [7:0]  ROW_OFFSET_RST = 8'd20;

    // Column and row frequencies in Hz.
    localparam int COL_HZ_0 = 1209;
    localparam int COL_HZ_1 = 1336;
    localparam int COL_HZ_2 = 1477;
    localparam int ROW_HZ_0 = 697;
    localparam int ROW_HZ_1 = 770;
    localparam int ROW_HZ_2 = 852;
    localparam int ROW_HZ_3 = 941;

    // Fixed-point constants for the sine table build.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam longint      ONE_Q30     = 64'sd1073741824;

    // ASCII key codes.
    localparam logic [7:0] KEY_ZERO = 8'h30;
    localparam logic [7:0] KEY_NINE = 8'h39;
    localparam logic [7:0] KEY_STAR = 8'h2A;
    localparam logic [7:0] KEY_HASH = 8'h23;

    // Depth of the queue between front and back.
    localparam int FIFO_DEPTH = 4;

    // Decoded key: valid flag plus column and row selects.
    typedef struct packed {
        logic       valid;
        logic [1:0] col;
        logic [1:0] row;
    } t_key_info;

    // Work handed from the front to the back.
    typedef struct packed {
        logic        err;
        logic        last;
        logic [31:0] col_phase;
        logic [31:0] row_phase;
    } t_job;

    // Map an ASCII key to its column and row on the keypad.
    function automatic t_key_info f_decode_key(input logic [7:0] key);
        t_key_info  info;
        logic [7:0] digit;
        info  = '{valid: 1'b1, col: 2'd0, row: 2'd3};
        digit = key - KEY_ZERO;
        if (key >= KEY_ZERO && key <= KEY_NINE) begin
            unique case (digit[3:0])
                4'd0:    begin info.col = 2'd1; info.row = 2'd3; end
                4'd1:    begin info.col = 2'd0; info.row = 2'd0; end
                4'd2:    begin info.col = 2'd1; info.row = 2'd0; end
                4'd3:    begin info.col = 2'd2; info.row = 2'd0; end
                4'd4:    begin info.col = 2'd0; info.row = 2'd1; end
                4'd5:    begin info.col = 2'd1; info.row = 2'd1; end
                4'd6:    begin info.col = 2'd2; info.row = 2'd1; end
                4'd7:    begin info.col = 2'd0; info.row = 2'd2; end
                4'd8:    begin info.col = 2'd1; info.row = 2'd2; end
                4'd9:    begin info.col = 2'd2; info.row = 2'd2; end
                default: info.valid = 1'b0;
            endcase
        end else if (key == KEY_STAR) begin
            info.col = 2'd0;
            info.row = 2'd3;
        end else if (key == KEY_HASH) begin
            info.col = 2'd2;
            info.row = 2'd3;
        end else begin
            info.valid = 1'b0;
        end
        return info;
    endfunction

endpackage

FILE: rtl/core/dtmf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DTMF front end
// Accepts start and tick transactions, decodes keys, runs the two phase
// accumulators and the burst counter, and queues one job per result.
// ----------------------------------------------------------------------------
module dtmf_front #(
    parameter int SAMPLE_RATE_HZ = dtmf_pkg::DEF_SAMPLE_RATE_HZ
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_cmd,
    input  logic [7:0]        i_key_code,
    input  logic [11:0]       i_tone_length,
    input  logic [7:0]        i_row_phase_offset,
    input  logic              i_full,
    output logic              o_push,
    output dtmf_pkg::t_job    o_job,
    output logic              o_active
);

    // Phase steps: round(f * 2^32 / rate), worked out at elaboration.
    localparam logic [63:0] HALF_RATE = 64'(SAMPLE_RATE_HZ / 2);
    localparam logic [63:0] RATE      = 64'(SAMPLE_RATE_HZ);
    localparam logic [31:0] STEP_COL_0 =
        32'(((64'(dtmf_pkg::COL_HZ_0) << 32) + HALF_RATE) / RATE);
    localparam logic [31:0] STEP_COL_1 =
        32'(((64'(dtmf_pkg::COL_HZ_1) << 32) + HALF_RATE) / RATE);
    localparam logic [31:0] STEP_COL_2 =
        32'(((64'(dtmf_pkg::COL_HZ_2) << 32) + HALF_RATE) / RATE);
    localparam logic [31:0] STEP_ROW_0 =
        32'(((64'(dtmf_pkg::ROW_HZ_0) << 32) + HALF_RATE) / RATE);
    localparam logic [31:0] STEP_ROW_1 =
        32'(((64'(dtmf_pkg::ROW_HZ_1) << 32) + HALF_RATE) / RATE);
    localparam logic [31:0] STEP_ROW_2 =
        32'(((64'(dtmf_pkg::ROW_HZ_2) << 32) + HALF_RATE) / RATE);
    localparam logic [31:0] STEP_ROW_3 =
        32'(((64'(dtmf_pkg::ROW_HZ_3) << 32) + HALF_RATE) / RATE);

    logic [31:0] r_col_phase, n_col_phase;
    logic [31:0] r_row_phase, n_row_phase;
    logic [31:0] r_col_step,  n_col_step;
    logic [31:0] r_row_step,  n_row_step;
    logic [11:0] r_count,     n_count;
    logic        r_active,    n_active;

    dtmf_pkg::t_key_info w_key;
    logic        w_accept;
    logic        w_is_start;
    logic        w_is_tick;
    logic [11:0] w_next_count;
    logic        w_is_last;
    logic [31:0] w_col_step;
    logic [31:0] w_row_step;

    // The front takes a transaction whenever the queue has room.
    assign o_ready      = !i_full;
    assign w_accept     = i_valid && !i_full;
    assign w_is_start   = (i_cmd == dtmf_pkg::CMD_START);
    assign w_is_tick    = (i_cmd == dtmf_pkg::CMD_TICK);
    assign w_key        = dtmf_pkg::f_decode_key(i_key_code);
    assign w_next_count = r_count + 12'd1;
    assign w_is_last    = (w_next_count == i_tone_length);

    // Step selection for the decoded key.
    always_comb begin
        case (w_key.col)
            2'd0:    w_col_step = STEP_COL_0;
            2'd1:    w_col_step = STEP_COL_1;
            default: w_col_step = STEP_COL_2;
        endcase
        case (w_key.row)
            2'd0:    w_row_step = STEP_ROW_0;
            2'd1:    w_row_step = STEP_ROW_1;
            2'd2:    w_row_step = STEP_ROW_2;
            default: w_row_step = STEP_ROW_3;
        endcase
    end

    // A bad key or a tick within a burst yields a job for the back end.
    assign o_push = w_accept && ((w_is_start && !w_key.valid) || (w_is_tick && r_active));
    assign o_job  = '{err:       w_is_start,
                      last:      w_is_tick && w_is_last,
                      col_phase: r_col_phase,
                      row_phase: r_row_phase};
    assign o_active = r_active;

    // Next state of the accumulators and the burst counter.
    always_comb begin
        n_col_phase = r_col_phase;
        n_row_phase = r_row_phase;
        n_col_step  = r_col_step;
        n_row_step  = r_row_step;
        n_count     = r_count;
        n_active    = r_active;
        if (w_accept) begin
            if (w_is_start) begin
                if (w_key.valid) begin
                    n_col_step  = w_col_step;
                    n_row_step  = w_row_step;
                    n_col_phase = '0;
                    n_row_phase = 32'(w_row_step * 32'(i_row_phase_offset));
                    n_count     = '0;
                    n_active    = 1'b1;
                end
            end else if (r_active) begin
                n_col_phase = r_col_phase + r_col_step;
                n_row_phase = r_row_phase + r_row_step;
                n_count     = w_next_count;
                if (w_is_last) begin
                    n_active = 1'b0;
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_phase <= '0;
            r_row_phase <= '0;
            r_col_step  <= '0;
            r_row_step  <= '0;
            r_count     <= '0;
            r_active    <= 1'b0;
        end else begin
            r_col_phase <= n_col_phase;
            r_row_phase <= n_row_phase;
            r_col_step  <= n_col_step;
            r_row_step  <= n_row_step;
            r_count     <= n_count;
            r_active    <= n_active;
        end
    end

endmodule

FILE: rtl/core/dtmf_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DTMF job queue
// Short first-word-fall-through queue that decouples the front end from the
// sample pipeline.
// ----------------------------------------------------------------------------
module dtmf_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dtmf_pkg::t_job i_data,
    input  logic           i_pop,
    output dtmf_pkg::t_job o_data,
    output logic           o_valid,
    output logic           o_full
);

    localparam int PTR_W = $clog2(dtmf_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(dtmf_pkg::FIFO_DEPTH + 1);

    dtmf_pkg::t_job    r_mem [dtmf_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count,  n_count;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_valid   = (r_count != '0);
    assign o_full    = (r_count == CNT_W'(dtmf_pkg::FIFO_DEPTH));
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(dtmf_pkg::FIFO_DEPTH - 1)) ? '0
                                                                      : r_wr_ptr + PTR_W'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(dtmf_pkg::FIFO_DEPTH - 1)) ? '0
                                                                      : r_rd_ptr + PTR_W'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: rtl/core/dtmf_synth.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DTMF sample synthesiser
// Four-stage pipeline: phase to table index, quarter-wave table read, sum and
// volume scaling, then truncation and saturation into the output register.
// ----------------------------------------------------------------------------
module dtmf_synth #(
    parameter int SINE_TABLE_DEPTH = dtmf_pkg::DEF_SINE_TABLE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  dtmf_pkg::t_job     i_job,
    output logic               o_pop,
    input  logic [15:0]        i_volume,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_sample,
    output logic               o_last,
    output logic               o_key_error
);

    localparam int QTR    = SINE_TABLE_DEPTH / 4;
    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int ADDR_W = $clog2(QTR + 1);
    localparam logic [IDX_W:0] Q1 = (IDX_W + 1)'(QTR);
    localparam logic [IDX_W:0] Q2 = (IDX_W + 1)'(2 * QTR);
    localparam logic [IDX_W:0] Q3 = (IDX_W + 1)'(3 * QTR);
    localparam logic [IDX_W:0] Q4 = (IDX_W + 1)'(4 * QTR);

    typedef struct packed {
        logic              neg;
        logic [ADDR_W-1:0] addr;
    } t_quad;

    // Quarter-wave entry k: Q30 Taylor series to x^13, rounded to Q1.15.
    function automatic logic [15:0] f_sine_entry(input int k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        int          n;
        x    = (64'(k) * dtmf_pkg::HALF_PI_Q30 + 64'(QTR / 2)) / 64'(QTR);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (n = 1; n <= 6; n++) begin
            term = (term * x2) >> 30;
            case (n)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                default: term = term / 64'd156;
            endcase
            if ((n & 1) != 0) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > dtmf_pkg::ONE_Q30) begin
            sum = dtmf_pkg::ONE_Q30;
        end
        return 16'((64'(sum) * 64'd32767 + 64'd536870912) >> 30);
    endfunction

    // Fold a full-turn table index onto the quarter table.
    function automatic t_quad f_fold(input logic [IDX_W-1:0] idx);
        t_quad           res;
        logic [IDX_W:0]  wide;
        wide = {1'b0, idx};
        if (wide < Q1) begin
            res = '{neg: 1'b0, addr: ADDR_W'(wide)};
        end else if (wide < Q2) begin
            res = '{neg: 1'b0, addr: ADDR_W'(Q2 - wide)};
        end else if (wide < Q3) begin
            res = '{neg: 1'b1, addr: ADDR_W'(wide - Q2)};
        end else begin
            res = '{neg: 1'b1, addr: ADDR_W'(Q4 - wide)};
        end
        return res;
    endfunction

    // Constant quarter-wave sine table.
    logic [15:0] w_rom [QTR + 1];
    for (genvar k = 0; k <= QTR; k++) begin : g_rom
        localparam logic [15:0] ENTRY = f_sine_entry(k);
        assign w_rom[k] = ENTRY;
    end

    // Pipeline registers.
    logic                    r1_valid, r2_valid, r3_valid, r_out_valid;
    logic                    r1_err, r1_last, r2_err, r2_last, r3_err, r3_last;
    logic [IDX_W-1:0]        r1_idx_c, r1_idx_r;
    logic [15:0]             r2_mag_c, r2_mag_r;
    logic                    r2_neg_c, r2_neg_r;
    logic signed [34:0]      r3_acc;
    logic signed [15:0]      r_sample;
    logic                    r_last, r_err;

    logic                    w_en1, w_en2, w_en3, w_en_out;
    logic [63:0]             w_prod_c, w_prod_r;
    t_quad                   w_quad_c, w_quad_r;
    logic signed [17:0]      w_sin_c, w_sin_r, w_sum;
    logic signed [34:0]      w_acc;
    logic signed [34:0]      w_biased;
    logic signed [18:0]      w_quot;
    logic signed [15:0]      w_sat;

    // Stall chain: a stage loads when it is empty or its successor moves.
    assign w_en_out = !r_out_valid || i_ready;
    assign w_en3    = !r3_valid || w_en_out;
    assign w_en2    = !r2_valid || w_en3;
    assign w_en1    = !r1_valid || w_en2;
    assign o_pop    = i_job_valid && w_en1;

    // Stage 1: table index = phase * depth / 2^32.
    assign w_prod_c = 64'(i_job.col_phase) * 64'(SINE_TABLE_DEPTH);
    assign w_prod_r = 64'(i_job.row_phase) * 64'(SINE_TABLE_DEPTH);

    // Stage 2: fold onto the quarter wave and read the table.
    assign w_quad_c = f_fold(r1_idx_c);
    assign w_quad_r = f_fold(r1_idx_r);

    // Stage 3: signed sum of both tones scaled by the volume.
    assign w_sin_c = r2_neg_c ? -$signed({2'b00, r2_mag_c}) : $signed({2'b00, r2_mag_c});
    assign w_sin_r = r2_neg_r ? -$signed({2'b00, r2_mag_r}) : $signed({2'b00, r2_mag_r});
    assign w_sum   = w_sin_c + w_sin_r;
    assign w_acc   = 35'(w_sum) * $signed({19'd0, i_volume});

    // Output stage: divide by 2^16 toward zero, then saturate.
    assign w_biased = r3_acc[34] ? (r3_acc + 35'sd65535) : r3_acc;
    assign w_quot   = w_biased[34:16];
    always_comb begin
        if (w_quot > 19'sd32767) begin
            w_sat = 16'sd32767;
        end else if (w_quot < -19'sd32768) begin
            w_sat = -16'sd32768;
        end else begin
            w_sat = w_quot[15:0];
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_en1) begin
                r1_valid <= i_job_valid;
            end
            if (w_en2) begin
                r2_valid <= r1_valid;
            end
            if (w_en3) begin
                r3_valid <= r2_valid;
            end
            if (w_en_out) begin
                r_out_valid <= r3_valid;
            end
        end
    end

    // Payload registers and registered table reads.
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_err   <= i_job.err;
            r1_last  <= i_job.last;
            r1_idx_c <= w_prod_c[32 +: IDX_W];
            r1_idx_r <= w_prod_r[32 +: IDX_W];
        end
        if (w_en2) begin
            r2_err   <= r1_err;
            r2_last  <= r1_last;
            r2_mag_c <= w_rom[w_quad_c.addr];
            r2_mag_r <= w_rom[w_quad_r.addr];
            r2_neg_c <= w_quad_c.neg;
            r2_neg_r <= w_quad_r.neg;
        end
        if (w_en3) begin
            r3_err  <= r2_err;
            r3_last <= r2_last;
            r3_acc  <= w_acc;
        end
        if (w_en_out) begin
            r_err    <= r3_err;
            r_last   <= r3_last && !r3_err;
            r_sample <= r3_err ? 16'sd0 : w_sat;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_sample    = r_sample;
    assign o_last      = r_last;
    assign o_key_error = r_err;

endmodule

FILE: rtl/core/dtmf_tone_generator.sv
`timescale 1ns / 1ps
// Results: a tick within a burst, or a bad key, passes through the job queue and
// the four sample pipeline stages; a good start or a tick while idle gives none.
// Throughput: one transaction per cycle unless the output or the full queue stalls it,
// set by the front-end phase accumulator loop; the four-stage sample pipeline keeps pace.
// Reset: synchronous, active low; registers return to their defaults, the
// burst goes idle and the queue and pipeline empty at once.
// ----------------------------------------------------------------------------
// DTMF tone generator
// Dual-tone sample generator with a decoding front end, a short job queue and
// a pipelined sine synthesiser.
// ----------------------------------------------------------------------------
module dtmf_tone_generator #(
    parameter int SAMPLE_RATE_HZ   = dtmf_pkg::DEF_SAMPLE_RATE_HZ,
    parameter int SINE_TABLE_DEPTH = dtmf_pkg::DEF_SINE_TABLE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_cmd,
    input  logic [7:0]                     i_key_code,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [15:0]             o_sample,
    output logic                           o_last,
    output logic                           o_key_error,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dtmf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                    i_cfg_data
);

    logic [15:0]    r_volume;
    logic [11:0]    r_tone_length;
    logic [7:0]     r_row_offset;

    logic           w_push;
    logic           w_full;
    logic           w_active;
    dtmf_pkg::t_job w_job_in;
    dtmf_pkg::t_job w_job_out;
    logic           w_job_valid;
    logic           w_pop;

    // Configuration registers; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume      <= dtmf_pkg::VOLUME_RST;
            r_tone_length <= dtmf_pkg::TONE_LEN_RST;
            r_row_offset  <= dtmf_pkg::ROW_OFFSET_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dtmf_pkg::REG_VOLUME:     r_volume      <= i_cfg_data;
                dtmf_pkg::REG_TONE_LEN:   r_tone_length <= i_cfg_data[11:0];
                dtmf_pkg::REG_ROW_OFFSET: r_row_offset  <= i_cfg_data[7:0];
                default:                  ;
            endcase
        end
    end

    // Front end: decode and phase accumulation.
    dtmf_front #(
        .SAMPLE_RATE_HZ(SAMPLE_RATE_HZ)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_cmd             (i_cmd),
        .i_key_code        (i_key_code),
        .i_tone_length     (r_tone_length),
        .i_row_phase_offset(r_row_offset),
        .i_full            (w_full),
        .o_push            (w_push),
        .o_job             (w_job_in),
        .o_active          (w_active)
    );

    // Job queue between front and back.
    dtmf_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data (w_job_in),
        .i_pop  (w_pop),
        .o_data (w_job_out),
        .o_valid(w_job_valid),
        .o_full (w_full)
    );

    // Back end: sample synthesis.
    dtmf_synth #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_synth (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(w_job_valid),
        .i_job      (w_job_out),
        .o_pop      (w_pop),
        .i_volume   (r_volume),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_sample   (o_sample),
        .o_last     (o_last),
        .o_key_error(o_key_error)
    );

    // The front never queues a job into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("job queued while the queue was full");

    // Queuing the final sample of a burst ends the burst.
    a_last_ends_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_job_in.last) |=> !w_active)
        else $error("burst still active after its final sample");

    // A key error result carries a zero sample and no end-of-burst mark.
    a_error_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_key_error) |-> ((o_sample == 16'sd0) && !o_last))
        else $error("key error result with sample or last set");

endmodule

FILE: tb/sv/dtmf_tone_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DTMF tone generator testbench
// Drives start and tick transactions into the generator, predicts every audio
// sample with a bit-exact software copy of the dual-tone synthesiser, and
// checks each output transaction in order under varied flow control.
// ----------------------------------------------------------------------------
module dtmf_tone_generator_tb;

    localparam int     CLK_PERIOD    = 10;
    localparam int     RESET_CYCLES  = 12;
    localparam int     QTR           = dtmf_pkg::DEF_SINE_TABLE_DEPTH / 4;
    localparam int     SETTLE_CYCLES = 16;
    localparam int     RANDOM_ITEMS  = 400;
    localparam int     DRAIN_LIMIT   = 20000;
    localparam longint TIMEOUT_NS    = 64'd5_000_000;

    // Index outside the register map; writes to it must be ignored.
    localparam logic [dtmf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
        logic               key_error;
    } t_tone_result;

    // DUT stimulus, driven to known values from time zero.
    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_valid     = 1'b0;
    logic                           i_cmd       = dtmf_pkg::CMD_START;
    logic [7:0]                     i_key_code  = 8'h00;
    logic                           i_ready     = 1'b0;
    logic                           i_cfg_valid = 1'b0;
    logic [dtmf_pkg::CFG_IDX_W-1:0] i_cfg_index = dtmf_pkg::REG_VOLUME;
    logic [15:0]                    i_cfg_data  = 16'h0000;

    logic                 o_ready;
    logic                 o_valid;
    logic signed [15:0]   o_sample;
    logic                 o_last;
    logic                 o_key_error;
    logic                 o_cfg_ready;

    // Predictor copy of the registers and the synthesiser state.
    logic [15:0] sine_quarter [0:QTR];
    logic [15:0] vol_reg    = dtmf_pkg::VOLUME_RST;
    logic [11:0] len_reg    = dtmf_pkg::TONE_LEN_RST;
    logic [7:0]  off_reg    = dtmf_pkg::ROW_OFFSET_RST;
    logic [31:0] col_ph     = '0;
    logic [31:0] row_ph     = '0;
    logic [31:0] col_inc    = '0;
    logic [31:0] row_inc    = '0;
    logic [11:0] sample_idx = '0;
    logic        burst_on   = 1'b0;

    t_tone_result expected_q [$];

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int error_count        = 0;
    int results_checked    = 0;
    int bursts_ended       = 0;
    int key_errors_seen    = 0;
    int saturated_seen     = 0;
    int items_sent         = 0;

    dtmf_tone_generator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_key_code  (i_key_code),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_sample    (o_sample),
        .o_last      (o_last),
        .o_key_error (o_key_error),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Free-running clock.
    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Output side back-pressure, redrawn on every falling edge.
    initial begin
        forever begin
            @(negedge i_clk);
            i_ready = ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Column and row frequencies of a keypad key; returns 0 for a bad key.
    function automatic bit key_tones(input logic [7:0] key, output int col_hz,
                                     output int row_hz);
        bit known;
        known  = 1'b1;
        col_hz = 0;
        row_hz = 0;
        case (key)
            "1": begin col_hz = dtmf_pkg::COL_HZ_0; row_hz = dtmf_pkg::ROW_HZ_0; end
            "2": begin col_hz = dtmf_pkg::COL_HZ_1; row_hz = dtmf_pkg::ROW_HZ_0; end
            "3": begin col_hz = dtmf_pkg::COL_HZ_2; row_hz = dtmf_pkg::ROW_HZ_0; end
            "4": begin col_hz = dtmf_pkg::COL_HZ_0; row_hz = dtmf_pkg::ROW_HZ_1; end
            "5": begin col_hz = dtmf_pkg::COL_HZ_1; row_hz = dtmf_pkg::ROW_HZ_1; end
            "6": begin col_hz = dtmf_pkg::COL_HZ_2; row_hz = dtmf_pkg::ROW_HZ_1; end
            "7": begin col_hz = dtmf_pkg::COL_HZ_0; row_hz = dtmf_pkg::ROW_HZ_2; end
            "8": begin col_hz = dtmf_pkg::COL_HZ_1; row_hz = dtmf_pkg::ROW_HZ_2; end
            "9": begin col_hz = dtmf_pkg::COL_HZ_2; row_hz = dtmf_pkg::ROW_HZ_2; end
            dtmf_pkg::KEY_ZERO: begin
                col_hz = dtmf_pkg::COL_HZ_1;
                row_hz = dtmf_pkg::ROW_HZ_3;
            end
            dtmf_pkg::KEY_STAR: begin
                col_hz = dtmf_pkg::COL_HZ_0;
                row_hz = dtmf_pkg::ROW_HZ_3;
            end
            dtmf_pkg::KEY_HASH: begin
                col_hz = dtmf_pkg::COL_HZ_2;
                row_hz = dtmf_pkg::ROW_HZ_3;
            end
            default: known = 1'b0;
        endcase
        return known;
    endfunction

    // Phase increment per sample, rounded to nearest.
    function automatic logic [31:0] phase_step(input int freq_hz);
        longint unsigned inc;
        inc = ((longint'(freq_hz) << 32) + dtmf_pkg::DEF_SAMPLE_RATE_HZ / 2)
              / dtmf_pkg::DEF_SAMPLE_RATE_HZ;
        return inc[31:0];
    endfunction

    // Signed Q1.15 sine of a 32-bit phase, folded out of the quarter table.
    function automatic int sine_at(input logic [31:0] phase);
        longint idx;
        idx = (longint'(phase) * (4 * QTR)) >>> 32;
        if (idx < QTR)          return int'(sine_quarter[idx]);
        else if (idx < 2 * QTR) return int'(sine_quarter[2 * QTR - idx]);
        else if (idx < 3 * QTR) return -int'(sine_quarter[idx - 2 * QTR]);
        else                    return -int'(sine_quarter[4 * QTR - idx]);
    endfunction

    // Key n of the twelve on the keypad.
    function automatic logic [7:0] dial_key(input int n);
        if (n < 10)       return dtmf_pkg::KEY_ZERO + 8'(n);
        else if (n == 10) return dtmf_pkg::KEY_STAR;
        else              return dtmf_pkg::KEY_HASH;
    endfunction

    // Any byte that is not a keypad key.
    function automatic logic [7:0] bad_key();
        logic [7:0] k;
        int         c;
        int         r;
        do k = 8'($urandom_range(255)); while (key_tones(k, c, r));
        return k;
    endfunction

    // Advance the predictor by one accepted transaction and queue its result.
    function automatic void predict_tone(input logic cmd, input logic [7:0] key);
        int           col_hz;
        int           row_hz;
        longint       mix;
        longint       scaled;
        logic [11:0]  next_idx;
        t_tone_result res;
        if (cmd == dtmf_pkg::CMD_START) begin
            items_sent++;
            if (!key_tones(key, col_hz, row_hz)) begin
                // A bad key leaves a running burst untouched.
                res.sample    = '0;
                res.last      = 1'b0;
                res.key_error = 1'b1;
                expected_q.push_back(res);
            end else begin
                col_inc    = phase_step(col_hz);
                row_inc    = phase_step(row_hz);
                col_ph     = '0;
                row_ph     = off_reg * row_inc;
                sample_idx = '0;
                burst_on   = 1'b1;
            end
        end else if (burst_on) begin
            items_sent++;
            mix    = longint'(sine_at(col_ph)) + longint'(sine_at(row_ph));
            scaled = (mix * longint'(vol_reg)) / 65536;
            if (scaled > 32767)
                scaled = 32767;
            else if (scaled < -32768)
                scaled = -32768;
            next_idx      = sample_idx + 12'd1;
            res.sample    = scaled[15:0];
            res.last      = (next_idx == len_reg);
            res.key_error = 1'b0;
            expected_q.push_back(res);
            col_ph     = col_ph + col_inc;
            row_ph     = row_ph + row_inc;
            sample_idx = next_idx;
            if (res.last)
                burst_on = 1'b0;
        end
    endfunction

    // Present one transaction, hold it until accepted, then predict it.
    task automatic send_item(input logic cmd, input logic [7:0] key);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid    = 1'b1;
        i_cmd      = cmd;
        i_key_code = key;
        do @(posedge i_clk); while (!o_ready);
        predict_tone(cmd, key);
    endtask

    // Stop sending and wait until every expected result has been returned.
    task automatic wait_for_idle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write over the configuration channel.
    task automatic write_reg(input logic [dtmf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            dtmf_pkg::REG_VOLUME:     vol_reg = data;
            dtmf_pkg::REG_TONE_LEN:   len_reg = data[11:0];
            dtmf_pkg::REG_ROW_OFFSET: off_reg = data[7:0];
            default:                  ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_item(dtmf_pkg::CMD_TICK, 8'($urandom_range(255)));
    endtask

    // Keep ticking until the predicted burst has ended.
    task automatic finish_burst();
        while (burst_on) send_item(dtmf_pkg::CMD_TICK, 8'($urandom_range(255)));
    endtask

    // Fresh register settings; mostly short bursts, unused bits randomised.
    task automatic randomise_registers();
        int          pick;
        logic [15:0] vol;
        logic [11:0] len;
        pick = $urandom_range(99);
        if (pick < 10)      vol = 16'h0000;
        else if (pick < 20) vol = 16'hFFFF;
        else                vol = 16'($urandom_range(65535));
        pick = $urandom_range(99);
        if (pick < 70)      len = 12'($urandom_range(1, 16));
        else if (pick < 90) len = 12'($urandom_range(17, 64));
        else                len = 12'($urandom_range(65, 120));
        write_reg(dtmf_pkg::REG_VOLUME, vol);
        write_reg(dtmf_pkg::REG_TONE_LEN, {4'($urandom_range(15)), len});
        write_reg(dtmf_pkg::REG_ROW_OFFSET, 16'($urandom_range(65535)));
        if ($urandom_range(3) == 0)
            write_reg(REG_UNUSED, 16'($urandom_range(65535)));
    endtask

    // Reset values: a burst at default volume, offset and length, with a bad
    // key in the middle of it.
    task automatic test_reset_defaults();
        send_item(dtmf_pkg::CMD_START, "5");
        send_ticks(2);
        send_item(dtmf_pkg::CMD_START, 8'hFF);
        send_ticks(1);
    endtask

    // Every key as a one-sample burst at full volume and maximum row offset,
    // then a tick with no burst running.
    task automatic test_keypad();
        wait_for_idle();
        write_reg(dtmf_pkg::REG_TONE_LEN, 16'd1);
        write_reg(dtmf_pkg::REG_VOLUME, 16'hFFFF);
        write_reg(dtmf_pkg::REG_ROW_OFFSET, 16'd255);
        for (int n = 0; n < 12; n++) begin
            send_item(dtmf_pkg::CMD_START, dial_key(n));
            send_ticks(1);
        end
        send_ticks(1);
    endtask

    // Bytes just either side of the valid key ranges, and the lowest byte.
    task automatic test_bad_keys();
        send_item(dtmf_pkg::CMD_START, dtmf_pkg::KEY_ZERO - 8'd1);
        send_item(dtmf_pkg::CMD_START, dtmf_pkg::KEY_NINE + 8'd1);
        send_item(dtmf_pkg::CMD_START, dtmf_pkg::KEY_STAR + 8'd1);
        send_item(dtmf_pkg::CMD_START, dtmf_pkg::KEY_HASH - 8'd1);
        send_item(dtmf_pkg::CMD_START, 8'h00);
    endtask

    // A burst at full volume (saturating) with no row offset, then a length
    // of zero, which must not end the burst early; the burst is closed by a
    // later length that lies above the count.
    task automatic test_length_extremes();
        wait_for_idle();
        write_reg(dtmf_pkg::REG_VOLUME, 16'hFFFF);
        write_reg(dtmf_pkg::REG_TONE_LEN, 16'd40);
        write_reg(dtmf_pkg::REG_ROW_OFFSET, 16'd0);
        send_item(dtmf_pkg::CMD_START, dtmf_pkg::KEY_HASH);
        finish_burst();
        send_ticks(1);
        wait_for_idle();
        write_reg(dtmf_pkg::REG_VOLUME, 16'h0000);
        write_reg(dtmf_pkg::REG_TONE_LEN, 16'hF000);
        send_item(dtmf_pkg::CMD_START, dtmf_pkg::KEY_ZERO);
        send_ticks(30);
        wait_for_idle();
        write_reg(dtmf_pkg::REG_TONE_LEN, 16'd35);
        finish_burst();
    endtask

    // Registers rewritten part way through a burst: the new volume and a
    // shorter length act at once; the row offset only counts from the next
    // start.
    task automatic test_register_changes();
        wait_for_idle();
        write_reg(dtmf_pkg::REG_TONE_LEN, 16'd60);
        write_reg(dtmf_pkg::REG_VOLUME, 16'h8000);
        write_reg(dtmf_pkg::REG_ROW_OFFSET, 16'd128);
        send_item(dtmf_pkg::CMD_START, "7");
        send_ticks(30);
        wait_for_idle();
        write_reg(dtmf_pkg::REG_TONE_LEN, 16'd40);
        write_reg(dtmf_pkg::REG_VOLUME, 16'h1234);
        write_reg(dtmf_pkg::REG_ROW_OFFSET, 16'hFF03);
        write_reg(REG_UNUSED, 16'hFFFF);
        finish_burst();
        send_item(dtmf_pkg::CMD_START, "9");
        send_ticks(4);
    endtask

    // Mostly well-formed bursts with random keys and lengths, broken up by
    // bad keys and restarts, plus stretches of random noise.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int item_goal);
        int first_item;
        int runs_left;
        int ticks;
        int pick;
        wait_for_idle();
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        first_item         = items_sent;
        runs_left          = 0;
        while (items_sent - first_item < item_goal) begin
            if (runs_left == 0) begin
                wait_for_idle();
                randomise_registers();
                runs_left = $urandom_range(1, 4);
            end
            runs_left--;
            if ($urandom_range(99) < 80) begin
                send_item(dtmf_pkg::CMD_START, dial_key($urandom_range(11)));
                ticks = $urandom_range(1, int'(len_reg) + 2);
                repeat (ticks) begin
                    pick = $urandom_range(99);
                    if (pick < 4)
                        send_item(dtmf_pkg::CMD_START, bad_key());
                    else if (pick < 6)
                        send_item(dtmf_pkg::CMD_START, dial_key($urandom_range(11)));
                    else
                        send_item(dtmf_pkg::CMD_TICK, 8'($urandom_range(255)));
                end
            end else begin
                repeat ($urandom_range(1, 6))
                    send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
            end
        end
    endtask

    // Compare each output transaction with the oldest expected result.
    always @(posedge i_clk) begin
        t_tone_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result: sample %0d last %0b key_error %0b",
                         $time, o_sample, o_last, o_key_error);
                error_count++;
            end else begin
                want = expected_q.pop_front();
                results_checked++;
                if (o_sample !== want.sample || o_last !== want.last ||
                    o_key_error !== want.key_error) begin
                    $display("%0t: mismatch: expected sample %0d last %0b key_error %0b",
                             $time, want.sample, want.last, want.key_error);
                    $display("%0t:           actual   sample %0d last %0b key_error %0b",
                             $time, o_sample, o_last, o_key_error);
                    error_count++;
                end
                if (want.last)
                    bursts_ended++;
                if (want.key_error)
                    key_errors_seen++;
                if (want.sample == 16'sh7FFF || want.sample == -16'sh8000)
                    saturated_seen++;
            end
        end
    end

    // Test sequence.
    initial begin
        int              k;
        int              n;
        int              spare;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          tsum;
        longint          rounded;

        // Quarter-wave sine table from a Q30 Taylor series.
        for (k = 0; k <= QTR; k++) begin
            x    = (longint'(k) * dtmf_pkg::HALF_PI_Q30 + QTR / 2) / QTR;
            x2   = (x * x) >> 30;
            term = x;
            tsum = longint'(x);
            for (n = 1; n <= 6; n++) begin
                term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    tsum = tsum - longint'(term);
                else
                    tsum = tsum + longint'(term);
            end
            if (tsum < 0)
                tsum = 0;
            if (tsum > dtmf_pkg::ONE_Q30)
                tsum = dtmf_pkg::ONE_Q30;
            rounded         = (tsum * 32767 + 64'sd536870912) >>> 30;
            sine_quarter[k] = rounded[15:0];
        end

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_keypad();
        test_bad_keys();
        test_length_extremes();
        test_register_changes();
        test_random_traffic(0, 0, RANDOM_ITEMS / 4);
        test_random_traffic(62, 0, RANDOM_ITEMS / 4);
        test_random_traffic(0, 62, RANDOM_ITEMS / 4);
        test_random_traffic(36, 36, RANDOM_ITEMS / 4);

        // Drain what is left, within a bound, then allow for late extras.
        @(negedge i_clk);
        i_valid = 1'b0;
        spare   = 0;
        while (expected_q.size() != 0 && spare < DRAIN_LIMIT) begin
            @(posedge i_clk);
            spare++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_q.size());
            error_count++;
        end

        $display("Run covered %0d transactions and %0d checked results.",
                 items_sent, results_checked);
        $display("Bursts ended: %0d, key errors: %0d, saturated samples: %0d.",
                 bursts_ended, key_errors_seen, saturated_seen);
        if (error_count == 0)
            $display("** dtmf_tone_generator: PASSED **");
        else
            $display("** dtmf_tone_generator: FAILED **");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timeout with %0d results outstanding", $time, expected_q.size());
        $display("** dtmf_tone_generator: FAILED **");
        $finish;
    end

endmodule
